// ===== hdl/nir_pkg.sv =====
`timescale 1ns / 1ps
// nir_pkg: shared sizes, register indexes, threshold record and window helpers
// for the NEC IR frame decoder. No dependencies.
package nir_pkg;

  // capture geometry
  localparam int MAX_ENTRIES        = 256;
  localparam int IDX_W              = $clog2(MAX_ENTRIES + 1);
  localparam int HDR_SEARCH_LIMIT   = 10;
  localparam int CS_W               = $clog2(HDR_SEARCH_LIMIT + 4);
  localparam logic [CS_W-1:0] CODE_START_RST = CS_W'(HDR_SEARCH_LIMIT + 3);
  localparam int MAX_BITS           = 32;
  localparam int BC_W               = $clog2(MAX_BITS + 1);
  localparam int BIT_IDX_W          = $clog2(MAX_BITS);

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_MARK    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_SPACE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RPT_SPACE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_MARK  = 3'd5;

  localparam logic [CFG_W-1:0] RST_HDR_MARK   = 16'd9000;
  localparam logic [CFG_W-1:0] RST_HDR_SPACE  = 16'd4500;
  localparam logic [CFG_W-1:0] RST_ZERO_SPACE = 16'd560;
  localparam logic [CFG_W-1:0] RST_ONE_SPACE  = 16'd1685;
  localparam logic [CFG_W-1:0] RST_RPT_SPACE  = 16'd2250;
  localparam logic [CFG_W-1:0] RST_BURST_MARK = 16'd560;

  // floor(x/5) for 19-bit x: x * ceil(2^21/5) >> 21 is exact over that range
  localparam logic [18:0] DIV5_MUL = 19'd419431;

  // Precomputed window bounds. Strict windows compare 5d against 4T and 6T;
  // bit windows compare d against floor(4T/5) and floor(6T/5).
  typedef struct packed {
    logic [17:0] hm4;
    logic [18:0] hm6;
    logic [17:0] hs4;
    logic [18:0] hs6;
    logic [17:0] rs4;
    logic [18:0] rs6;
    logic [17:0] bm4;
    logic [18:0] bm6;
    logic [15:0] zlo;
    logic [16:0] zhi;
    logic [15:0] olo;
    logic [16:0] ohi;
  } nir_thr_t;

  function automatic logic [17:0] x4(input logic [CFG_W-1:0] t);
    return {t, 2'b00};
  endfunction

  function automatic logic [18:0] x6(input logic [CFG_W-1:0] t);
    return {1'b0, t, 2'b00} + {2'b00, t, 1'b0};
  endfunction

  function automatic logic [16:0] div5(input logic [18:0] x);
    logic [37:0] p;
    p = 38'(x) * 38'(DIV5_MUL);
    return p[37:21];
  endfunction

  function automatic logic [15:0] bit_lo(input logic [CFG_W-1:0] t);
    logic [16:0] q;
    q = div5({1'b0, x4(t)});
    return q[15:0];
  endfunction

  function automatic logic [16:0] bit_hi(input logic [CFG_W-1:0] t);
    return div5(x6(t));
  endfunction

endpackage

// ===== hdl/nec_ir_frame_decoder_unit.sv =====
`timescale 1ns / 1ps
// nec_ir_frame_decoder_unit: top level of the NEC IR frame decoder.
// Depends on nir_pkg and nir_cfg_regs.
//
// Usage:
//  - Input stream: one word per captured pulse. in_tdata carries the pulse
//    length in microseconds, in_tuser the pin level, in_tlast closes the
//    capture. Pulses are numbered from zero within a capture.
//  - Output stream: one word per capture, issued for the in_tlast word. It
//    holds address, command, inverted command and the running repeat count.
//  - Config port: cfg_we/cfg_index/cfg_wdata write one of six timing values
//    (header mark, header space, zero space, one space, repeat space, burst
//    mark). Write only while the decoder is idle.
//  - Throughput: one word per cycle unless a closing word stalls. Each word is
//    decoded by window compares on precomputed bounds in the cycle after it is taken.
//  - Result path: the closing pulse is decoded from the input register into the
//    output register, which holds the result word valid.
//  - Reset: decode state, repeat counter and timing values go to defaults
//    (9000/4500/560/1685/2250/560 us).
//  - Stall: a held result does not block pulses that produce no result; only
//    a second closing word waits in the input register, and in_tready drops.
module nec_ir_frame_decoder_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // input pulses
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // [15:0] duration_us
  input  logic                          in_tuser,   // [0] level
  input  logic                          in_tlast,   // is_last
  // decoded frames
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [47:0]                   out_tdata,  // [15:0] address, [23:16] command,
                                                    // [31:24] cmd_inv,
                                                    // [47:32] repeat_count
  // timing registers
  input  logic                          cfg_we,
  input  logic [nir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nir_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int IDX_W = nir_pkg::IDX_W;
  localparam int CS_W  = nir_pkg::CS_W;
  localparam int BC_W  = nir_pkg::BC_W;

  // decode phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_CODE   = 2'd1;
  localparam logic [1:0] PH_REPEAT = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  nir_pkg::nir_thr_t thr;

  nir_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .thr       (thr)
  );

  // ---------------- input register ----------------
  logic        stg_v_r;
  logic [15:0] stg_dur_r;
  logic        stg_lvl_r;
  logic        stg_last_r;

  logic out_v_r;
  logic out_free;
  logic stage_adv;
  logic in_acc;

  assign out_free  = !out_v_r || out_tready;
  // a closing word needs the output register; other words always move on
  assign stage_adv = stg_v_r && (!stg_last_r || out_free);
  assign in_tready = !stg_v_r || stage_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_acc) begin
      stg_v_r <= 1'b1;
    end else if (stage_adv) begin
      stg_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_dur_r  <= in_tdata;
      stg_lvl_r  <= in_tuser;
      stg_last_r <= in_tlast;
    end
  end

  // ---------------- decode state ----------------
  logic [IDX_W-1:0] idx_r,  idx_nxt;
  logic [1:0]       ph_r,   ph_nxt;
  logic [CS_W-1:0]  cs_r,   cs_nxt;
  logic [1:0]       pm_r,   pm_nxt;   // [0] first element matched, [1] two-element prefix
  logic [31:0]      bits_r, bits_nxt;
  logic [BC_W-1:0]  bc_r,   bc_nxt;
  logic [15:0]      cnt_r,  cnt_nxt;

  // window hits for the word in the input register
  logic [18:0] d5;
  logic        hit_hm, hit_hs, hit_rs, hit_bm;
  logic        zero_hit, one_hit;

  assign d5 = {1'b0, stg_dur_r, 2'b00} + {3'b000, stg_dur_r};

  assign hit_hm =  stg_lvl_r && (d5 > {1'b0, thr.hm4}) && (d5 < thr.hm6);
  assign hit_hs = !stg_lvl_r && (d5 > {1'b0, thr.hs4}) && (d5 < thr.hs6);
  assign hit_rs = !stg_lvl_r && (d5 > {1'b0, thr.rs4}) && (d5 < thr.rs6);
  assign hit_bm =  stg_lvl_r && (d5 > {1'b0, thr.bm4}) && (d5 < thr.bm6);

  assign zero_hit = (stg_dur_r >= thr.zlo) && ({1'b0, stg_dur_r} <= thr.zhi);
  assign one_hit  = (stg_dur_r >= thr.olo) && ({1'b0, stg_dur_r} <= thr.ohi);

  always_comb begin
    idx_nxt  = idx_r;
    ph_nxt   = ph_r;
    cs_nxt   = cs_r;
    pm_nxt   = pm_r;
    bits_nxt = bits_r;
    bc_nxt   = bc_r;
    cnt_nxt  = cnt_r;
    // past the capture limit the index saturates and nothing is decoded
    if (idx_r < IDX_W'(nir_pkg::MAX_ENTRIES)) begin
      if (ph_r == PH_HEADER) begin
        if (pm_r[0] && hit_hs) begin
          cs_nxt = idx_r[CS_W-1:0] + CS_W'(2);
          ph_nxt = PH_CODE;
        end else if (idx_r >= IDX_W'(nir_pkg::HDR_SEARCH_LIMIT)) begin
          // no header found: assume the default position
          cs_nxt = nir_pkg::CODE_START_RST;
          ph_nxt = PH_CODE;
        end
        pm_nxt = {1'b0, (ph_nxt == PH_HEADER) && hit_hm};
      end else if (ph_r == PH_CODE) begin
        // data spaces sit on every second entry from the code start
        if ((idx_r >= IDX_W'(cs_r)) && (idx_r[0] == cs_r[0])) begin
          if (zero_hit) begin
            if (bc_r < BC_W'(nir_pkg::MAX_BITS)) begin
              bc_nxt = bc_r + BC_W'(1);
            end
          end else if (one_hit) begin
            if (bc_r < BC_W'(nir_pkg::MAX_BITS)) begin
              bits_nxt[bc_r[nir_pkg::BIT_IDX_W-1:0]] = 1'b1;
              bc_nxt = bc_r + BC_W'(1);
            end
          end else begin
            ph_nxt = PH_REPEAT;
            pm_nxt = 2'b00;
          end
        end
      end
      // repeat triple search, also on the word that ended the code
      if (ph_nxt == PH_REPEAT) begin
        if (pm_nxt[1] && hit_bm) begin
          cnt_nxt = cnt_r + 16'd1;
          ph_nxt  = PH_DONE;
          pm_nxt  = 2'b00;
        end else begin
          pm_nxt = {pm_nxt[0] && hit_rs, hit_hm};
        end
      end
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      ph_r   <= PH_HEADER;
      cs_r   <= nir_pkg::CODE_START_RST;
      pm_r   <= 2'b00;
      bits_r <= '0;
      bc_r   <= '0;
      cnt_r  <= '0;
    end else if (stage_adv) begin
      cnt_r <= cnt_nxt;
      if (stg_last_r) begin
        // capture closed: start over, keep the repeat count
        idx_r  <= '0;
        ph_r   <= PH_HEADER;
        cs_r   <= nir_pkg::CODE_START_RST;
        pm_r   <= 2'b00;
        bits_r <= '0;
        bc_r   <= '0;
      end else begin
        idx_r  <= idx_nxt;
        ph_r   <= ph_nxt;
        cs_r   <= cs_nxt;
        pm_r   <= pm_nxt;
        bits_r <= bits_nxt;
        bc_r   <= bc_nxt;
      end
    end
  end

  // ---------------- output register ----------------
  logic [47:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= stage_adv && stg_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && stage_adv && stg_last_r) begin
      out_data_r <= {cnt_nxt, bits_nxt[31:24], bits_nxt[23:16],
                     bits_nxt[7:0], bits_nxt[15:8]};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // ---------------- checks ----------------
  // input only stalls behind a closing word that waits for the output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (stg_v_r && stg_last_r && out_v_r && !out_tready))
    else $error("input stalled without a blocked closing word");

  // a closing word leaves the decoder in its start state and a result pending
  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_adv && stg_last_r) |=> (idx_r == '0 && ph_r == PH_HEADER && out_v_r))
    else $error("capture close did not restart decoding");

  // no bits can be collected before the header phase is left
  a_header_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_HEADER) |-> (bc_r == '0 && bits_r == '0))
    else $error("bits present during header search");

  // bit counter never passes the frame width
  a_bc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_adv && !stg_last_r) |=> (bc_r <= BC_W'(nir_pkg::MAX_BITS)))
    else $error("bit counter overflow");

endmodule

// ===== hdl/nir_cfg_regs.sv =====
`timescale 1ns / 1ps
// nir_cfg_regs: timing registers of the NEC IR decoder, kept as window bounds.
// Depends on nir_pkg.
module nir_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [nir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nir_pkg::CFG_W-1:0]     cfg_wdata,
  output nir_pkg::nir_thr_t             thr
);

  nir_pkg::nir_thr_t thr_r;

  // bounds of the incoming value; the bit bounds take one reciprocal multiply each
  logic [17:0] w4;
  logic [18:0] w6;
  logic [15:0] wlo;
  logic [16:0] whi;

  assign w4  = nir_pkg::x4(cfg_wdata);
  assign w6  = nir_pkg::x6(cfg_wdata);
  assign wlo = nir_pkg::bit_lo(cfg_wdata);
  assign whi = nir_pkg::bit_hi(cfg_wdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.hm4 <= nir_pkg::x4(nir_pkg::RST_HDR_MARK);
      thr_r.hm6 <= nir_pkg::x6(nir_pkg::RST_HDR_MARK);
      thr_r.hs4 <= nir_pkg::x4(nir_pkg::RST_HDR_SPACE);
      thr_r.hs6 <= nir_pkg::x6(nir_pkg::RST_HDR_SPACE);
      thr_r.rs4 <= nir_pkg::x4(nir_pkg::RST_RPT_SPACE);
      thr_r.rs6 <= nir_pkg::x6(nir_pkg::RST_RPT_SPACE);
      thr_r.bm4 <= nir_pkg::x4(nir_pkg::RST_BURST_MARK);
      thr_r.bm6 <= nir_pkg::x6(nir_pkg::RST_BURST_MARK);
      thr_r.zlo <= nir_pkg::bit_lo(nir_pkg::RST_ZERO_SPACE);
      thr_r.zhi <= nir_pkg::bit_hi(nir_pkg::RST_ZERO_SPACE);
      thr_r.olo <= nir_pkg::bit_lo(nir_pkg::RST_ONE_SPACE);
      thr_r.ohi <= nir_pkg::bit_hi(nir_pkg::RST_ONE_SPACE);
    end else if (cfg_we) begin
      unique case (cfg_index)
        nir_pkg::CFG_HDR_MARK: begin
          thr_r.hm4 <= w4;
          thr_r.hm6 <= w6;
        end
        nir_pkg::CFG_HDR_SPACE: begin
          thr_r.hs4 <= w4;
          thr_r.hs6 <= w6;
        end
        nir_pkg::CFG_ZERO_SPACE: begin
          thr_r.zlo <= wlo;
          thr_r.zhi <= whi;
        end
        nir_pkg::CFG_ONE_SPACE: begin
          thr_r.olo <= wlo;
          thr_r.ohi <= whi;
        end
        nir_pkg::CFG_RPT_SPACE: begin
          thr_r.rs4 <= w4;
          thr_r.rs6 <= w6;
        end
        nir_pkg::CFG_BURST_MARK: begin
          thr_r.bm4 <= w4;
          thr_r.bm6 <= w6;
        end
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  assign thr = thr_r;

endmodule

// ===== sim/nec_ir_frame_decoder_unit_tb.sv =====
`timescale 1ns / 1ps
// nec_ir_frame_decoder_unit_tb: self-checking bench for the NEC IR frame decoder.
// Feeds pulse captures, predicts every decoded frame word and checks the output.
// Depends on nir_pkg and nec_ir_frame_decoder_unit.
module nec_ir_frame_decoder_unit_tb;

  // decoder progress within one capture
  typedef enum logic [1:0] {SEEK_HDR, READ_BITS, SEEK_RPT, FRAME_DONE} dec_phase_t;

  typedef struct packed {
    logic [15:0] dur;
    logic        lvl;
    logic        last;
  } pulse_t;

  typedef struct packed {
    logic [15:0] address;
    logic [7:0]  command;
    logic [7:0]  check;
    logic [15:0] repeats;
  } frame_t;

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [15:0]                   in_tdata   = '0;   // [15:0] duration_us
  logic                          in_tuser   = 1'b0; // [0] level
  logic                          in_tlast   = 1'b0; // is_last
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [47:0]                   out_tdata;         // [15:0] address, [23:16] command,
                                                    // [31:24] cmd_inv, [47:32] repeat_count
  logic                          cfg_we     = 1'b0;
  logic [nir_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
  logic [nir_pkg::CFG_W-1:0]     cfg_wdata  = '0;

  nec_ir_frame_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial forever #6 clk = ~clk;

  // hard stop, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // ------------------------------------------------------------------
  // Frame predictor: its own copy of the timing registers and the
  // per-capture decode state. Runs once per accepted pulse word.
  // ------------------------------------------------------------------
  logic [nir_pkg::CFG_W-1:0] timing [0:5];
  logic [nir_pkg::IDX_W-1:0] entry_pos;
  dec_phase_t                dec_phase;
  logic [nir_pkg::CS_W-1:0]  bits_from;   // first bit slot of the capture
  logic [1:0]                seen;        // bit0: last word began a pair/triple, bit1: two in a row
  logic [31:0]               got_bits;
  logic [5:0]                bit_cnt;
  logic [15:0]               rpt_cnt;     // survives captures, wraps

  pulse_t cap_q[$];       // capture under construction
  pulse_t pulse_q[$];     // words waiting for the driver
  frame_t frames_due[$];  // predicted output words, oldest first
  int     queued = 0;
  int     taken  = 0;
  int     errors = 0;

  // header/repeat windows: open interval 0.8T..1.2T, level must agree
  function automatic bit fits_strict(int unsigned d, bit lvl, int unsigned nom, bit want);
    return lvl == want && 5 * d > 4 * nom && 5 * d < 6 * nom;
  endfunction

  // bit windows: closed, floored bounds, level ignored
  function automatic bit fits_bit(int unsigned d, int unsigned nom);
    return d >= (4 * nom) / 5 && d <= (6 * nom) / 5;
  endfunction

  function automatic void new_capture();
    entry_pos = '0;
    dec_phase = SEEK_HDR;
    bits_from = nir_pkg::CS_W'(nir_pkg::HDR_SEARCH_LIMIT + 3);
    seen      = '0;
    got_bits  = '0;
    bit_cnt   = '0;
  endfunction

  function automatic void decode_pulse(logic [15:0] d, logic lvl, logic last);
    frame_t f;
    bit     m0, m1, m2;
    // pulses past the capture buffer size are dropped, index saturates
    if (entry_pos < nir_pkg::MAX_ENTRIES) begin
      if (dec_phase == SEEK_HDR) begin
        if (seen[0] && fits_strict(d, lvl, timing[nir_pkg::CFG_HDR_SPACE], 1'b0)) begin
          bits_from = nir_pkg::CS_W'(entry_pos + 2);
          dec_phase = READ_BITS;
        end else if (entry_pos >= nir_pkg::HDR_SEARCH_LIMIT) begin
          // no header in the search range: assume one just past it
          bits_from = nir_pkg::CS_W'(nir_pkg::HDR_SEARCH_LIMIT + 3);
          dec_phase = READ_BITS;
        end
        seen = (dec_phase == SEEK_HDR &&
                fits_strict(d, lvl, timing[nir_pkg::CFG_HDR_MARK], 1'b1)) ? 2'b01 : 2'b00;
      end else if (dec_phase == READ_BITS) begin
        if (entry_pos >= bits_from && entry_pos[0] == bits_from[0]) begin
          // zero window wins on overlap; bits past 32 are dropped
          if (fits_bit(d, timing[nir_pkg::CFG_ZERO_SPACE])) begin
            if (bit_cnt < nir_pkg::MAX_BITS) bit_cnt++;
          end else if (fits_bit(d, timing[nir_pkg::CFG_ONE_SPACE])) begin
            if (bit_cnt < nir_pkg::MAX_BITS) begin
              got_bits[bit_cnt[4:0]] = 1'b1;
              bit_cnt++;
            end
          end else begin
            dec_phase = SEEK_RPT;
            seen      = '0;
          end
        end
      end
      // the pulse that ended the bits is already a repeat candidate
      if (dec_phase == SEEK_RPT) begin
        m0 = fits_strict(d, lvl, timing[nir_pkg::CFG_HDR_MARK], 1'b1);
        m1 = fits_strict(d, lvl, timing[nir_pkg::CFG_RPT_SPACE], 1'b0);
        m2 = fits_strict(d, lvl, timing[nir_pkg::CFG_BURST_MARK], 1'b1);
        if (seen[1] && m2) begin
          rpt_cnt++;
          dec_phase = FRAME_DONE;
          seen      = '0;
        end else begin
          seen = {seen[0] && m1, m0};
        end
      end
      entry_pos++;
    end
    if (last) begin
      f.address = {got_bits[7:0], got_bits[15:8]};
      f.command = got_bits[23:16];
      f.check   = got_bits[31:24];
      f.repeats = rpt_cnt;
      frames_due.push_back(f);
      new_capture();
    end
  endfunction

  // ------------------------------------------------------------------
  // Capture builders
  // ------------------------------------------------------------------
  function automatic void put(int unsigned d, bit lvl);
    pulse_t p;
    p.dur  = 16'(d);
    p.lvl  = lvl;
    p.last = 1'b0;
    cap_q.push_back(p);
  endfunction

  function automatic void close_capture();
    pulse_t p;
    int     i;
    p      = cap_q[cap_q.size() - 1];
    p.last = 1'b1;
    cap_q[cap_q.size() - 1] = p;
    for (i = 0; i < cap_q.size(); i++) pulse_q.push_back(cap_q[i]);
    queued += cap_q.size();
    cap_q.delete();
  endfunction

  // value in the open window of nom, often on its edge, rarely just outside
  function automatic int unsigned strict_val(int unsigned nom);
    int unsigned lo, hi, r;
    lo = (4 * nom) / 5 + 1;
    hi = (6 * nom - 1) / 5;
    if (hi < lo) hi = lo;
    r = $urandom_range(0, 49);
    if (r == 0) return lo - 1;
    if (r == 1) return hi + 1;
    if (r < 6) return lo;
    if (r < 10) return hi;
    return $urandom_range(hi, lo);
  endfunction

  function automatic int unsigned bit_val(int unsigned nom);
    int unsigned lo, hi, r;
    lo = (4 * nom) / 5;
    hi = (6 * nom) / 5;
    r  = $urandom_range(0, 49);
    if (r == 0) return lo - 1;
    if (r == 1) return hi + 1;
    if (r < 5) return lo;
    if (r < 8) return hi;
    return $urandom_range(hi, lo);
  endfunction

  // marks between bit slots are never looked at
  function automatic int unsigned mark_val();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 65535);
    return strict_val(timing[nir_pkg::CFG_BURST_MARK]);
  endfunction

  function automatic int unsigned any_bit_val();
    return bit_val($urandom_range(0, 1) ? timing[nir_pkg::CFG_ONE_SPACE]
                                        : timing[nir_pkg::CFG_ZERO_SPACE]);
  endfunction

  // repeat triples, with or without a long gap that ends the bits first
  function automatic void add_tails(int tails);
    int t;
    for (t = 0; t < tails; t++) begin
      if ($urandom_range(0, 1)) put(65535, 1'b0);
      put(strict_val(timing[nir_pkg::CFG_HDR_MARK]), 1'b1);
      put(strict_val(timing[nir_pkg::CFG_RPT_SPACE]), 1'b0);
      put(strict_val(timing[nir_pkg::CFG_BURST_MARK]), 1'b1);
    end
  endfunction

  // proper frame: optional junk, header pair, bits, stop mark, repeats, junk
  function automatic void add_frame(int lead, int nbits, int tails, int pad);
    int i;
    for (i = 0; i < lead; i++) put($urandom_range(0, 65535), 1'($urandom_range(0, 1)));
    put(strict_val(timing[nir_pkg::CFG_HDR_MARK]), 1'b1);
    put(strict_val(timing[nir_pkg::CFG_HDR_SPACE]), 1'b0);
    for (i = 0; i < nbits; i++) begin
      put(mark_val(), 1'b1);
      put(any_bit_val(), 1'b0);
    end
    put(mark_val(), 1'b1);
    add_tails(tails);
    for (i = 0; i < pad; i++) put($urandom_range(0, 65535), 1'($urandom_range(0, 1)));
    close_capture();
  endfunction

  // no header within the search range: bits start at the fallback slot
  function automatic void add_headerless(int nbits, int tails);
    int i;
    for (i = 0; i < nir_pkg::HDR_SEARCH_LIMIT + 3; i++) put($urandom_range(0, 65535), i[0]);
    for (i = 0; i < nbits; i++) begin
      put(any_bit_val(), 1'b0);
      put(mark_val(), 1'b1);
    end
    add_tails(tails);
    close_capture();
  endfunction

  // near-miss soup: window values in random order, levels sometimes flipped
  function automatic void add_noise(int len);
    int          i;
    int unsigned d;
    bit          lvl;
    for (i = 0; i < len; i++) begin
      case ($urandom_range(0, 5))
        0: begin d = strict_val(timing[nir_pkg::CFG_HDR_MARK]);   lvl = 1'b1; end
        1: begin d = strict_val(timing[nir_pkg::CFG_HDR_SPACE]);  lvl = 1'b0; end
        2: begin d = strict_val(timing[nir_pkg::CFG_RPT_SPACE]);  lvl = 1'b0; end
        3: begin d = strict_val(timing[nir_pkg::CFG_BURST_MARK]); lvl = 1'b1; end
        4: begin d = any_bit_val();                               lvl = 1'b0; end
        default: begin
          d   = $urandom_range(0, 65535);
          lvl = 1'($urandom_range(0, 1));
        end
      endcase
      if ($urandom_range(0, 7) == 0) lvl = !lvl;
      put(d, lvl);
    end
    close_capture();
  endfunction

  function automatic void random_captures(int target);
    int start, r, nbits, tails;
    start = queued;
    while (queued - start < target) begin
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 6))
        0:       nbits = $urandom_range(0, 31);
        1:       nbits = $urandom_range(33, 40);
        default: nbits = 32;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: tails = 0;
        4:          tails = 2;
        default:    tails = 1;
      endcase
      if (r < 40)
        add_frame(($urandom_range(0, 2) == 0) ? $urandom_range(1, 9) : 0, nbits, tails,
                  ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0);
      else if (r < 55)
        add_headerless($urandom_range(0, 34), tails);
      else
        add_noise($urandom_range(1, 24));
    end
  endfunction

  // ------------------------------------------------------------------
  // Idle pattern: mostly short gaps, a few long ones
  // ------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic report(string what);
    errors++;
    if (errors <= 200) $display("ERR %0t: %s", $time, what);
  endtask

  // ------------------------------------------------------------------
  // Driver: one pulse word per handshake, gaps drawn after each word.
  // tx_steady switches off idling for stretches.
  // ------------------------------------------------------------------
  int tx_hold   = 0;
  bit tx_steady = 1'b0;

  always @(posedge clk) begin : drive
    pulse_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_pulse(in_tdata, in_tuser, in_tlast);
        taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_hold > 0) begin
          tx_hold--;
          in_tvalid <= 1'b0;
        end else if (pulse_q.size() != 0) begin
          nxt = pulse_q.pop_front();
          in_tdata  <= nxt.dur;
          in_tuser  <= nxt.lvl;
          in_tlast  <= nxt.last;
          in_tvalid <= 1'b1;
          tx_hold   = tx_steady ? 0 : pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      if ($urandom_range(0, 299) == 0) tx_steady = !tx_steady;
    end
  end

  // ------------------------------------------------------------------
  // Monitor: every frame word against the oldest prediction; random
  // backpressure with its own no-stall stretches.
  // ------------------------------------------------------------------
  int rx_stall  = 0;
  bit rx_steady = 1'b0;

  always @(posedge clk) begin : watch
    frame_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (frames_due.size() == 0) begin
          report($sformatf("frame word %h with none predicted", out_tdata));
        end else begin
          want = frames_due.pop_front();
          if (out_tdata[15:0] !== want.address)
            report($sformatf("address %h, want %h", out_tdata[15:0], want.address));
          if (out_tdata[23:16] !== want.command)
            report($sformatf("command %h, want %h", out_tdata[23:16], want.command));
          if (out_tdata[31:24] !== want.check)
            report($sformatf("cmd_inv %h, want %h", out_tdata[31:24], want.check));
          if (out_tdata[47:32] !== want.repeats)
            report($sformatf("repeat_count %0d, want %0d", out_tdata[47:32], want.repeats));
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 3) == 0) rx_stall = pick_gap();
      end
      if ($urandom_range(0, 299) == 0) rx_steady = !rx_steady;
    end
  end

  // ------------------------------------------------------------------
  // Sequencing and timing register writes
  // ------------------------------------------------------------------

  // all words taken, all frames out, then a margin for the two-stage pipe
  task automatic settle();
    int n;
    n = 0;
    while (taken != queued) @(posedge clk);
    while (frames_due.size() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (8) @(posedge clk);
  endtask

  // one register per cycle; write enable stays high across the burst
  task automatic cfg_beat(logic [nir_pkg::CFG_IDX_W-1:0] idx, logic [nir_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we      <= 1'b1;
    cfg_index   <= idx;
    cfg_wdata   <= val;
    timing[idx] = val;
  endtask

  task automatic load_timing(logic [nir_pkg::CFG_W-1:0] hm, hs, zs, os, rs, bm);
    cfg_beat(nir_pkg::CFG_HDR_MARK, hm);
    cfg_beat(nir_pkg::CFG_HDR_SPACE, hs);
    cfg_beat(nir_pkg::CFG_ZERO_SPACE, zs);
    cfg_beat(nir_pkg::CFG_ONE_SPACE, os);
    cfg_beat(nir_pkg::CFG_RPT_SPACE, rs);
    cfg_beat(nir_pkg::CFG_BURST_MARK, bm);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stim
    int ph;
    timing[nir_pkg::CFG_HDR_MARK]   = nir_pkg::RST_HDR_MARK;
    timing[nir_pkg::CFG_HDR_SPACE]  = nir_pkg::RST_HDR_SPACE;
    timing[nir_pkg::CFG_ZERO_SPACE] = nir_pkg::RST_ZERO_SPACE;
    timing[nir_pkg::CFG_ONE_SPACE]  = nir_pkg::RST_ONE_SPACE;
    timing[nir_pkg::CFG_RPT_SPACE]  = nir_pkg::RST_RPT_SPACE;
    timing[nir_pkg::CFG_BURST_MARK] = nir_pkg::RST_BURST_MARK;
    rpt_cnt = '0;
    new_capture();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset timing: one-word captures at the duration extremes
    put(0, 1'b0);
    close_capture();
    put(65535, 1'b1);
    close_capture();
    // header at index 0 with nominal values, capture ends inside the bits: 1,0,1
    put(9000, 1'b1); put(4500, 1'b0);
    put(560, 1'b1);  put(1685, 1'b0);
    put(560, 1'b1);  put(560, 1'b0);
    put(560, 1'b1);  put(1685, 1'b0);
    close_capture();
    // window edges: header just inside both ends, zero at its floor, one at its ceiling
    put(7201, 1'b1); put(5399, 1'b0);
    put(560, 1'b1);  put(448, 1'b0);
    put(560, 1'b1);  put(2022, 1'b0);
    close_capture();
    // mark exactly at 0.8T is outside, so no header
    put(7200, 1'b1); put(4500, 1'b0);
    close_capture();

    // overlong capture: index saturates, last still closes it
    add_frame(0, 32, 1, 190);
    random_captures(175);

    for (ph = 1; ph <= 4; ph++) begin
      settle();
      case (ph)
        1: load_timing(16'd4500, 16'd2250, 16'd280, 16'd843, 16'd1125, 16'd280);
        2: load_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        3: load_timing(16'd50000, 16'd50000, 16'd40000, 16'd50000, 16'd50000, 16'd50000);
        default: load_timing(16'($urandom_range(1, 50000)), 16'($urandom_range(1, 50000)),
                             16'($urandom_range(1, 50000)), 16'($urandom_range(1, 50000)),
                             16'($urandom_range(1, 50000)), 16'($urandom_range(1, 50000)));
      endcase
      if (ph == 3) add_frame(0, 32, 1, 190);
      random_captures(175);
    end

    settle();
    if (frames_due.size() != 0)
      report($sformatf("%0d predicted frames never came out", frames_due.size()));
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
